[hdl/ede_pkg.sv]
// Shared types and constants for the edit distance engine.
package ede_pkg;

  localparam int CHAR_W   = 8;
  localparam int DIST_W   = 7;
  localparam int DIST_MAX = 127;

  // One loaded character or end marker.
  typedef struct packed {
    logic              which_string;
    logic              has_char;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_string;
  } in_item_t;

  // One distance result.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } out_item_t;

  // Control bits that ride with each token through the cell row.
  typedef struct packed {
    logic valid;
    logic last;
  } tok_ctl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

endpackage

[hdl/ede_cell.sv]
// One cell of the systolic row: holds one first-string character and one DP row.
module ede_cell #(
  parameter int IDX = 0,
  parameter int LW  = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    init,
  input  logic                    wr_en,
  input  logic [LW-1:0]           wr_idx,
  input  logic [7:0]              wr_ch,
  input  logic [LW-1:0]           first_len,
  input  ede_pkg::tok_ctl_t       in_ctl,
  input  logic [7:0]              in_ch,
  input  logic [LW-1:0]           in_d,
  output ede_pkg::tok_ctl_t       out_ctl,
  output logic [7:0]              out_ch,
  output logic [LW-1:0]           out_d
);
  import ede_pkg::*;

  logic [CHAR_W-1:0] ch_r;
  logic [LW-1:0]     own_r;
  logic [LW-1:0]     diag_r;
  tok_ctl_t          ctl_r;
  logic [CHAR_W-1:0] och_r;
  logic [LW-1:0]     od_r;

  logic              active;
  logic [LW-1:0]     mn;
  logic [LW-1:0]     cost;

  // Cells past the first string's length just forward the token.
  assign active = LW'(IDX) < first_len;

  // Unit-cost recurrence: match takes the diagonal, else min of three plus one.
  always_comb begin
    mn = own_r;
    if (in_d < mn) mn = in_d;
    if (diag_r < mn) mn = diag_r;
    if (ch_r == in_ch) begin
      cost = diag_r;
    end else begin
      cost = mn + LW'(1);
    end
  end

  // Character capture while loading.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == LW'(IDX))) begin
      ch_r <= wr_ch;
    end
  end

  // Row state: seeded with the first column, then updated per passing token.
  always_ff @(posedge clk) begin
    if (init) begin
      own_r  <= LW'(IDX + 1);
      diag_r <= LW'(IDX);
    end else if (in_ctl.valid && active) begin
      own_r  <= cost;
      diag_r <= in_d;
    end
  end

  // Token control toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  // Token payload toward the next cell.
  always_ff @(posedge clk) begin
    och_r <= in_ch;
    od_r  <= active ? cost : in_d;
  end

  assign out_ctl = ctl_r;
  assign out_ch  = och_r;
  assign out_d   = od_r;

endmodule

[hdl/edit_distance_engine_unit.sv]
// Top level of the Levenshtein edit distance engine.
// Usage:
//   Input channel (in_valid/in_stall/in_item) loads the first string one byte
//   per transaction (which_string = 0), then the second (which_string = 1).
//   has_char = 0 stores nothing; bytes beyond MAX_LEN are dropped and flag
//   overflow. The transaction with which_string = 1 and end_of_string = 1
//   starts the computation.
//   Loading accepts a new transaction whenever in_stall is low. After the
//   final transaction the second string is streamed from its memory, one
//   byte per cycle, through a row of MAX_LEN cells holding the first string;
//   the result then passes res_r and the output register to out_valid. With
//   an empty second string the result is the first string's length.
//   in_stall is high from the final transaction until the result has moved
//   into the output register; a result held by out_stall holds back only the
//   next result, not loading or the start of a new computation. Reset
//   empties both strings and the output.
module edit_distance_engine_unit #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ede_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ede_pkg::out_item_t out_item
);
  import ede_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  state_t            state_r;
  logic [LW-1:0]     first_len_r, first_len_nxt;
  logic [LW-1:0]     second_len_r, second_len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CHAR_W-1:0] second_mem [MAX_LEN];
  logic [CHAR_W-1:0] mem_q_r;
  logic [AW-1:0]     rd_cnt_r;
  logic              iss_r;
  tok_ctl_t          src_ctl_r;
  logic [LW-1:0]     rd_j_r;
  logic [LW-1:0]     rd_j;
  out_item_t         res_r;
  out_item_t         out_item_r;
  logic              out_valid_r;

  logic              accept;
  logic              trigger;
  logic              wr_first;
  logic              wr_second;
  logic              start_run;
  logic              out_free;

  tok_ctl_t          chain_ctl [MAX_LEN+1];
  logic [CHAR_W-1:0] chain_ch  [MAX_LEN+1];
  logic [LW-1:0]     chain_d   [MAX_LEN+1];

  // Clamp a distance to the 7-bit result field.
  function automatic logic [DIST_W-1:0] sat_dist(input logic [LW-1:0] v);
    if (int'(v) > DIST_MAX) begin
      return DIST_W'(DIST_MAX);
    end
    return DIST_W'(v);
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign trigger  = accept && in_item.which_string && in_item.end_of_string;
  assign wr_first  = accept && in_item.has_char && !in_item.which_string &&
                     (first_len_r < LW'(MAX_LEN));
  assign wr_second = accept && in_item.has_char && in_item.which_string &&
                     (second_len_r < LW'(MAX_LEN));
  assign out_free = !out_valid_r || !out_stall;

  // Length and overflow bookkeeping for the current transaction.
  always_comb begin
    first_len_nxt  = first_len_r;
    second_len_nxt = second_len_r;
    ovf_nxt        = ovf_r;
    if (wr_first) first_len_nxt = first_len_r + LW'(1);
    if (wr_second) second_len_nxt = second_len_r + LW'(1);
    if (accept && in_item.has_char && !wr_first && !wr_second) ovf_nxt = 1'b1;
  end

  assign start_run = trigger && (second_len_nxt != '0);

  // Second-string storage.
  always_ff @(posedge clk) begin
    if (wr_second) begin
      second_mem[second_len_r[AW-1:0]] <= in_item.char_code;
    end
    mem_q_r <= second_mem[rd_cnt_r];
  end

  // Sequencer, lengths and result capture.
  assign rd_j = LW'(rd_cnt_r) + LW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      first_len_r  <= '0;
      second_len_r <= '0;
      ovf_r        <= 1'b0;
      iss_r        <= 1'b0;
      rd_cnt_r     <= '0;
      src_ctl_r    <= '0;
    end else begin
      src_ctl_r.valid <= iss_r;
      src_ctl_r.last  <= iss_r && (rd_j == second_len_r);
      case (state_r)
        ST_IDLE: begin
          first_len_r  <= first_len_nxt;
          second_len_r <= second_len_nxt;
          ovf_r        <= ovf_nxt;
          if (trigger) begin
            if (start_run) begin
              state_r  <= ST_RUN;
              iss_r    <= 1'b1;
              rd_cnt_r <= '0;
            end else begin
              state_r      <= ST_HOLD;
              first_len_r  <= '0;
              second_len_r <= '0;
              ovf_r        <= 1'b0;
            end
          end
        end
        ST_RUN: begin
          if (iss_r) begin
            if (rd_j == second_len_r) begin
              iss_r <= 1'b0;
            end else begin
              rd_cnt_r <= rd_cnt_r + AW'(1);
            end
          end
          if (chain_ctl[MAX_LEN].valid && chain_ctl[MAX_LEN].last) begin
            state_r      <= ST_HOLD;
            first_len_r  <= '0;
            second_len_r <= '0;
            ovf_r        <= 1'b0;
          end
        end
        ST_HOLD: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result staging: empty-second-string shortcut or end of the cell row.
  always_ff @(posedge clk) begin
    rd_j_r <= rd_j;
    if (state_r == ST_IDLE && trigger && !start_run) begin
      res_r.distance <= sat_dist(first_len_nxt);
      res_r.overflow <= ovf_nxt;
    end else if (state_r == ST_RUN && chain_ctl[MAX_LEN].valid &&
                 chain_ctl[MAX_LEN].last) begin
      res_r.distance <= sat_dist(chain_d[MAX_LEN]);
      res_r.overflow <= ovf_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_HOLD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_HOLD && out_free) begin
      out_item_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Token source: second-string byte plus the top DP row value j.
  assign chain_ctl[0] = src_ctl_r;
  assign chain_ch[0]  = mem_q_r;
  assign chain_d[0]   = rd_j_r;

  // Row of cells, one per first-string position.
  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    ede_cell #(
      .IDX (g),
      .LW  (LW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .init      (start_run),
      .wr_en     (wr_first),
      .wr_idx    (first_len_r),
      .wr_ch     (in_item.char_code),
      .first_len (first_len_r),
      .in_ctl    (chain_ctl[g]),
      .in_ch     (chain_ch[g]),
      .in_d      (chain_d[g]),
      .out_ctl   (chain_ctl[g+1]),
      .out_ch    (chain_ch[g+1]),
      .out_d     (chain_d[g+1])
    );
  end

  // Tokens only leave the row while a computation runs.
  a_tok_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    chain_ctl[MAX_LEN].valid |-> state_r == ST_RUN)
    else $error("token left cell row outside a computation");

  // Stored lengths never pass the capacity.
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    first_len_r <= LW'(MAX_LEN) && second_len_r <= LW'(MAX_LEN))
    else $error("string length beyond capacity");

  // The final token always ends the run.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && chain_ctl[MAX_LEN].valid && chain_ctl[MAX_LEN].last)
      |=> state_r == ST_HOLD)
    else $error("run did not end on final token");

  // A run never starts with an empty second string.
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> second_len_r != '0)
    else $error("run with empty second string");

endmodule
